FILE: sv/gr2fb_pkg.sv
// shared types, constants and palette for the glyph row pixel writer
`default_nettype none
package gr2fb_pkg;

  localparam int GLYPH_WIDTH    = 8;
  localparam int GLYPH_HEIGHT   = 16;
  localparam int MAX_LINE_WIDTH = 4096;

  localparam int LINE_W   = 13;
  localparam int BPP_W    = 3;
  localparam int SIZE_W   = 4;
  localparam int POS_W    = 5;
  localparam int COORD_W  = 12;
  localparam int ROW_W    = 4;
  localparam int Y_W      = 13;
  localparam int OFFSET_W = 26;
  localparam int WORD_W   = 32;
  localparam int LANE_W   = $clog2(GLYPH_WIDTH);
  localparam int CNT_W    = $clog2(GLYPH_WIDTH + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_LINE_WIDTH     = 3'd0;
  localparam cfg_index_t REG_BYTES_PER_PIX  = 3'd1;
  localparam cfg_index_t REG_RED_SIZE       = 3'd2;
  localparam cfg_index_t REG_GREEN_SIZE     = 3'd3;
  localparam cfg_index_t REG_BLUE_SIZE      = 3'd4;
  localparam cfg_index_t REG_RED_POSITION   = 3'd5;
  localparam cfg_index_t REG_GREEN_POSITION = 3'd6;
  localparam cfg_index_t REG_BLUE_POSITION  = 3'd7;

  typedef struct packed {
    logic [LINE_W-1:0] line_width_pixels;
    logic [BPP_W-1:0]  bytes_per_pixel;
    logic [SIZE_W-1:0] red_size;
    logic [SIZE_W-1:0] green_size;
    logic [SIZE_W-1:0] blue_size;
    logic [POS_W-1:0]  red_position;
    logic [POS_W-1:0]  green_position;
    logic [POS_W-1:0]  blue_position;
  } cfg_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] byte_offset;
    logic [WORD_W-1:0]   pixel_word;
  } lane_t;

  // 16 colour palette as {red, green, blue}
  function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'h0:    rgb = 24'h000000;
      4'h1:    rgb = 24'h0000A8;
      4'h2:    rgb = 24'h00A800;
      4'h3:    rgb = 24'h00A8A8;
      4'h4:    rgb = 24'hA80000;
      4'h5:    rgb = 24'hA800A8;
      4'h6:    rgb = 24'hA85700;
      4'h7:    rgb = 24'hA8A8A8;
      4'h8:    rgb = 24'h575757;
      4'h9:    rgb = 24'h5757FF;
      4'hA:    rgb = 24'h57FF57;
      4'hB:    rgb = 24'h57FFFF;
      4'hC:    rgb = 24'hFF5757;
      4'hD:    rgb = 24'hFF57FF;
      4'hE:    rgb = 24'hFFFF57;
      4'hF:    rgb = 24'hFFFFFF;
      default: rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

endpackage
`default_nettype wire

FILE: sv/gr2fb_colour.sv
// palette lookup and packing of one colour into a pixel word
`default_nettype none
module gr2fb_colour (
  input  wire logic [3:0]                       idx,
  input  wire gr2fb_pkg::cfg_t                  cfg,
  output logic [gr2fb_pkg::WORD_W-1:0]          word
);

  function automatic logic [gr2fb_pkg::WORD_W-1:0] place(
    input logic [7:0]                      value,
    input logic [gr2fb_pkg::SIZE_W-1:0]    size,
    input logic [gr2fb_pkg::POS_W-1:0]     pos
  );
    logic [gr2fb_pkg::SIZE_W-1:0]  keep;
    logic [gr2fb_pkg::WORD_W-1:0]  field;
    // sizes above eight keep the whole byte, size zero shifts everything out
    keep  = (size > 4'd8) ? 4'd8 : size;
    field = {24'b0, value >> (4'd8 - keep)};
    return field << pos;
  endfunction

  logic [23:0] rgb;

  always_comb begin
    rgb  = gr2fb_pkg::palette_rgb(idx);
    word = place(rgb[23:16], cfg.red_size,   cfg.red_position)
         | place(rgb[15:8],  cfg.green_size, cfg.green_position)
         | place(rgb[7:0],   cfg.blue_size,  cfg.blue_position);
  end

endmodule
`default_nettype wire

FILE: sv/gr2fb_lane.sv
// one pixel lane: byte offset and colour choice for one column of the row
`default_nettype none
module gr2fb_lane (
  input  wire logic [gr2fb_pkg::OFFSET_W-1:0] row_base,
  input  wire logic [gr2fb_pkg::COORD_W-1:0]  cell_x,
  input  wire logic [gr2fb_pkg::LANE_W-1:0]   lane_index,
  input  wire logic [gr2fb_pkg::BPP_W-1:0]    bytes_per_pixel,
  input  wire logic                           glyph_bit,
  input  wire logic [gr2fb_pkg::WORD_W-1:0]   fg_word,
  input  wire logic [gr2fb_pkg::WORD_W-1:0]   bg_word,
  output gr2fb_pkg::lane_t                    result
);

  logic [gr2fb_pkg::OFFSET_W-1:0] pixel_index;

  always_comb begin
    pixel_index = row_base
                + {{(gr2fb_pkg::OFFSET_W-gr2fb_pkg::COORD_W){1'b0}}, cell_x}
                + {{(gr2fb_pkg::OFFSET_W-gr2fb_pkg::LANE_W){1'b0}}, lane_index};
    // wraps modulo 2^26
    result.byte_offset = pixel_index
                       * {{(gr2fb_pkg::OFFSET_W-gr2fb_pkg::BPP_W){1'b0}}, bytes_per_pixel};
    result.pixel_word  = glyph_bit ? fg_word : bg_word;
  end

endmodule
`default_nettype wire

FILE: sv/gr2fb_serializer.sv
// merge stage: holds the eight lane results and sends one write per cycle
`default_nettype none
module gr2fb_serializer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            load,
  input  wire gr2fb_pkg::lane_t                lanes [gr2fb_pkg::GLYPH_WIDTH],
  input  wire logic [gr2fb_pkg::BPP_W-1:0]     bytes_per_pixel,
  output logic                                 can_load,
  output logic                                 result_valid,
  output logic [gr2fb_pkg::OFFSET_W-1:0]       byte_offset,
  output logic [gr2fb_pkg::WORD_W-1:0]         pixel_word,
  output logic [gr2fb_pkg::BPP_W-1:0]          byte_count,
  output logic                                 last_pixel
);

  localparam int N = gr2fb_pkg::GLYPH_WIDTH;

  gr2fb_pkg::lane_t               bank [N];
  logic [gr2fb_pkg::BPP_W-1:0]    count_bytes;
  logic [gr2fb_pkg::CNT_W-1:0]    remaining;
  logic [gr2fb_pkg::CNT_W-1:0]    remaining_next;

  // a new row may enter while the last write of the previous one goes out
  assign can_load = (remaining <= gr2fb_pkg::CNT_W'(1));

  always_comb begin
    if (load) begin
      remaining_next = gr2fb_pkg::CNT_W'(N);
    end else if (remaining != '0) begin
      remaining_next = remaining - gr2fb_pkg::CNT_W'(1);
    end else begin
      remaining_next = remaining;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else begin
      remaining <= remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < N; k++) begin
        bank[k] <= lanes[k];
      end
      count_bytes <= bytes_per_pixel;
    end else if (remaining != '0) begin
      for (int k = 0; k < N - 1; k++) begin
        bank[k] <= bank[k + 1];
      end
    end
  end

  assign result_valid = (remaining != '0);
  assign byte_offset  = bank[0].byte_offset;
  assign pixel_word   = bank[0].pixel_word;
  assign byte_count   = count_bytes;
  assign last_pixel   = (remaining == gr2fb_pkg::CNT_W'(1));

`ifndef SYNTHESIS
  a_writes_in_a_row: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_pixel) |=> result_valid)
    else $error("row writes broken up");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (remaining > gr2fb_pkg::CNT_W'(1))
      |=> (remaining == $past(remaining) - gr2fb_pkg::CNT_W'(1)))
    else $error("write counter skipped");
`endif

endmodule
`default_nettype wire

FILE: sv/glyph_row_to_framebuffer_pixels_unit.sv
// glyph row to framebuffer pixel writes, top level
//
//  channel   direction  transfer                   payload
//  command   in         start && !busy             glyph_bits attribute cell_x cell_y glyph_row
//  result    out        result_valid, every cycle  byte_offset pixel_word byte_count last_pixel
//  config    in         cfg_we                     cfg_index cfg_data
//
// a row passes input capture, stage 2 and the write bank before its first write, then gives eight writes
// the sustained row rate is set by the single write per cycle at the output
// stages: input capture, row multiply and colour packing, eight lanes into the write bank
// rst is synchronous; after it the config registers hold their default mode
// results cannot be held off; busy stalls commands while both stages hold a row and the bank is still draining
// rows with bytes_per_pixel of 0 or above 4 are taken and dropped
`default_nettype none
module glyph_row_to_framebuffer_pixels_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [7:0]                            glyph_bits,
  input  wire logic [7:0]                            attribute,
  input  wire logic [gr2fb_pkg::COORD_W-1:0]         cell_x,
  input  wire logic [gr2fb_pkg::COORD_W-1:0]         cell_y,
  input  wire logic [gr2fb_pkg::ROW_W-1:0]           glyph_row,
  output logic                                       result_valid,
  output logic [gr2fb_pkg::OFFSET_W-1:0]             byte_offset,
  output logic [gr2fb_pkg::WORD_W-1:0]               pixel_word,
  output logic [gr2fb_pkg::BPP_W-1:0]                byte_count,
  output logic                                       last_pixel,
  input  wire logic                                  cfg_we,
  input  wire logic [gr2fb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gr2fb_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int N = gr2fb_pkg::GLYPH_WIDTH;

  gr2fb_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_width_pixels <= gr2fb_pkg::LINE_W'(640);
      cfg.bytes_per_pixel   <= gr2fb_pkg::BPP_W'(4);
      cfg.red_size          <= gr2fb_pkg::SIZE_W'(8);
      cfg.green_size        <= gr2fb_pkg::SIZE_W'(8);
      cfg.blue_size         <= gr2fb_pkg::SIZE_W'(8);
      cfg.red_position      <= gr2fb_pkg::POS_W'(16);
      cfg.green_position    <= gr2fb_pkg::POS_W'(8);
      cfg.blue_position     <= gr2fb_pkg::POS_W'(0);
    end else if (cfg_we) begin
      case (cfg_index)
        gr2fb_pkg::REG_LINE_WIDTH:     cfg.line_width_pixels <= cfg_data;
        gr2fb_pkg::REG_BYTES_PER_PIX:  cfg.bytes_per_pixel   <= cfg_data[2:0];
        gr2fb_pkg::REG_RED_SIZE:       cfg.red_size          <= cfg_data[3:0];
        gr2fb_pkg::REG_GREEN_SIZE:     cfg.green_size        <= cfg_data[3:0];
        gr2fb_pkg::REG_BLUE_SIZE:      cfg.blue_size         <= cfg_data[3:0];
        gr2fb_pkg::REG_RED_POSITION:   cfg.red_position      <= cfg_data[4:0];
        gr2fb_pkg::REG_GREEN_POSITION: cfg.green_position    <= cfg_data[4:0];
        gr2fb_pkg::REG_BLUE_POSITION:  cfg.blue_position     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // handshake and stage control
  logic accept;
  logic bpp_ok;
  logic s1_valid;
  logic s1_valid_next;
  logic s2_valid;
  logic s2_valid_next;
  logic s2_free;
  logic bank_load;
  logic can_load;

  // stage 1 payload
  logic [7:0]                      s1_bits;
  logic [7:0]                      s1_attr;
  logic [gr2fb_pkg::COORD_W-1:0]   s1_cx;
  logic [gr2fb_pkg::Y_W-1:0]       s1_y;

  // stage 2 payload
  logic [7:0]                       s2_bits;
  logic [gr2fb_pkg::COORD_W-1:0]    s2_cx;
  logic [gr2fb_pkg::OFFSET_W-1:0]   s2_row_base;
  logic [gr2fb_pkg::WORD_W-1:0]     s2_fg;
  logic [gr2fb_pkg::WORD_W-1:0]     s2_bg;

  logic [gr2fb_pkg::LINE_W-1:0]     stride;
  logic [gr2fb_pkg::WORD_W-1:0]     fg_word;
  logic [gr2fb_pkg::WORD_W-1:0]     bg_word;
  gr2fb_pkg::lane_t                 lane_results [N];

  assign bpp_ok    = (cfg.bytes_per_pixel != '0)
                   && (cfg.bytes_per_pixel <= gr2fb_pkg::BPP_W'(4));
  assign bank_load = s2_valid && can_load;
  assign s2_free   = !s2_valid || can_load;
  assign busy      = s1_valid && !s2_free;
  assign accept    = start && !busy;

  always_comb begin
    if (accept) begin
      s1_valid_next = bpp_ok;
    end else if (s2_free) begin
      s1_valid_next = 1'b0;
    end else begin
      s1_valid_next = s1_valid;
    end
    if (s2_free) begin
      s2_valid_next = s1_valid;
    end else begin
      s2_valid_next = s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
      s2_valid <= s2_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      // rows past the glyph height draw background only
      s1_bits <= (int'(glyph_row) < gr2fb_pkg::GLYPH_HEIGHT) ? glyph_bits : 8'h00;
      s1_attr <= attribute;
      s1_cx   <= cell_x;
      s1_y    <= {1'b0, cell_y} + {{(gr2fb_pkg::Y_W-gr2fb_pkg::ROW_W){1'b0}}, glyph_row};
    end
  end

  assign stride = (cfg.line_width_pixels > gr2fb_pkg::LINE_W'(gr2fb_pkg::MAX_LINE_WIDTH))
                ? gr2fb_pkg::LINE_W'(gr2fb_pkg::MAX_LINE_WIDTH)
                : cfg.line_width_pixels;

  gr2fb_colour u_fg_colour (
    .idx  (s1_attr[3:0]),
    .cfg  (cfg),
    .word (fg_word)
  );

  gr2fb_colour u_bg_colour (
    .idx  (s1_attr[7:4]),
    .cfg  (cfg),
    .word (bg_word)
  );

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_bits     <= s1_bits;
      s2_cx       <= s1_cx;
      s2_row_base <= {{(gr2fb_pkg::OFFSET_W-gr2fb_pkg::Y_W){1'b0}}, s1_y}
                   * {{(gr2fb_pkg::OFFSET_W-gr2fb_pkg::LINE_W){1'b0}}, stride};
      s2_fg       <= fg_word;
      s2_bg       <= bg_word;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_lane
    gr2fb_lane u_lane (
      .row_base        (s2_row_base),
      .cell_x          (s2_cx),
      .lane_index      (gr2fb_pkg::LANE_W'(i)),
      .bytes_per_pixel (cfg.bytes_per_pixel),
      .glyph_bit       (s2_bits[N - 1 - i]),
      .fg_word         (s2_fg),
      .bg_word         (s2_bg),
      .result          (lane_results[i])
    );
  end

  gr2fb_serializer u_serializer (
    .clk             (clk),
    .rst             (rst),
    .load            (bank_load),
    .lanes           (lane_results),
    .bytes_per_pixel (cfg.bytes_per_pixel),
    .can_load        (can_load),
    .result_valid    (result_valid),
    .byte_offset     (byte_offset),
    .pixel_word      (pixel_word),
    .byte_count      (byte_count),
    .last_pixel      (last_pixel)
  );

`ifndef SYNTHESIS
  a_busy_means_held: assert property (@(posedge clk) disable iff (rst)
    busy |-> (s1_valid && s2_valid && !can_load))
    else $error("busy without a held row");

  a_row_enters: assert property (@(posedge clk) disable iff (rst)
    (accept && bpp_ok) |=> s1_valid)
    else $error("transferred row lost at capture");
`endif

endmodule
`default_nettype wire
